@@ design/sfpd_pkg.sv @@
// Shared types, widths and register codes for the scanline finder pattern detector.
package sfpd_pkg;

    // Field widths
    localparam int unsigned COORD_W = 12;
    localparam int unsigned CFG_W   = 13;
    localparam int unsigned TOL_W   = 9;
    localparam int unsigned INV_W   = 16;
    localparam int unsigned BOUND_W = 13;
    localparam int unsigned BND3_W  = 15;
    localparam int unsigned DATA_W  = 16;
    localparam int unsigned IDX_W   = 3;

    // Longest supported line, caps the line length register
    localparam logic [CFG_W-1:0] LINE_MAX = 13'd4096;

    // Register indexes of the configuration port
    localparam logic [IDX_W-1:0] CFG_LINE_LENGTH = 3'd0;
    localparam logic [IDX_W-1:0] CFG_MAX_RUN     = 3'd1;
    localparam logic [IDX_W-1:0] CFG_MIN_RUN     = 3'd2;
    localparam logic [IDX_W-1:0] CFG_TOL         = 3'd3;
    localparam logic [IDX_W-1:0] CFG_INV_TOL     = 3'd4;

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0] RST_LINE_LENGTH = 13'd640;
    localparam logic [CFG_W-1:0] RST_MAX_RUN     = 13'd128;
    localparam logic [CFG_W-1:0] RST_MIN_RUN     = 13'd1;
    localparam logic [TOL_W-1:0] RST_TOL         = 9'd179;
    localparam logic [INV_W-1:0] RST_INV_TOL     = 16'd366;

    typedef struct packed {
        logic [CFG_W-1:0] line_length;
        logic [CFG_W-1:0] max_run;
        logic [CFG_W-1:0] min_run;
        logic [TOL_W-1:0] tolerance_q8;
        logic [INV_W-1:0] inv_tolerance_q8;
    } t_cfg;

    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] marker_row;
        logic [COORD_W-1:0] outer_run;
        logic [COORD_W-1:0] gap_run;
        logic [COORD_W-1:0] center_run;
    } t_result;

endpackage

@@ design/sfpd_scan.sv @@
// Run-length state machine that finds the 1:1:3:1:1 pattern along a scanline.
module sfpd_scan (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sfpd_pkg::t_cfg               i_cfg,
    input  logic                         i_step,
    input  logic [sfpd_pkg::COORD_W-1:0] i_column,
    input  logic [sfpd_pkg::COORD_W-1:0] i_row,
    input  logic                         i_pixel,
    input  logic                         i_aux_pixel,
    output logic                         o_emit,
    output sfpd_pkg::t_result            o_result
);
    import sfpd_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_OUTER1 = 3'd1,
        PH_GAP1   = 3'd2,
        PH_CENTER = 3'd3,
        PH_GAP2   = 3'd4,
        PH_OUTER2 = 3'd5,
        PH_MARK   = 3'd6
    } t_phase;

    localparam logic [COORD_W-1:0] COUNT_SAT = '1;

    t_phase               r_phase, n_phase;
    logic [COORD_W-1:0]   r_run, n_run;
    logic [COORD_W-1:0]   r_run1, r_run2, r_run3;
    logic [COORD_W-1:0]   r_first_col, r_last_col, r_prev_row;
    logic [BOUND_W-1:0]   r_lower, r_upper, n_lower, n_upper;
    logic [BND3_W-1:0]    r_lower3, r_upper3;
    logic                 r_prev_pixel, r_prev_aux;

    logic                 step_edge, exit_ok, advance, overrun;
    logic [CFG_W-1:0]     line_cap, col_p1;
    logic [COORD_W-1:0]   run_inc;
    logic [BOUND_W-1:0]   run_w;
    logic [BND3_W-1:0]    run_w3, max_run3, limit, n_run_w3;
    logic                 within1, within3;
    logic [20:0]          prod_lo;
    logic [27:0]          prod_hi;
    t_phase               ph_a;

    // Edge detect; the marker phase always takes the edge path
    assign step_edge = (i_pixel != r_prev_pixel) || (r_phase == PH_MARK);

    assign line_cap = (i_cfg.line_length > LINE_MAX) ? LINE_MAX : i_cfg.line_length;
    assign col_p1   = {1'b0, i_column} + 13'd1;
    assign run_inc  = (r_run == COUNT_SAT) ? r_run : r_run + 12'd1;

    // Tolerance checks against the bounds set by the first outer run
    assign run_w    = {1'b0, r_run};
    assign run_w3   = {3'b000, r_run};
    assign max_run3 = {2'b00, i_cfg.max_run} + {1'b0, i_cfg.max_run, 1'b0};
    assign within1  = (run_w >= r_lower) && (run_w <= r_upper) && (run_w <= i_cfg.max_run);
    assign within3  = (run_w3 >= r_lower3) && (run_w3 <= r_upper3) && (run_w3 <= max_run3);

    // Bounds from the current first-run length; lower never exceeds 13 bits
    assign prod_lo = 21'(r_run) * 21'(i_cfg.tolerance_q8);
    assign prod_hi = 28'(r_run) * 28'(i_cfg.inv_tolerance_q8);
    assign n_lower = prod_lo[20:8];
    assign n_upper = (|prod_hi[27:21]) ? '1 : prod_hi[20:8];

    // Exit test of the current phase
    always_comb begin
        unique case (r_phase)
            PH_IDLE:   exit_ok = !i_pixel && (i_column != '0) && r_prev_aux;
            PH_OUTER1: exit_ok = i_pixel && ({1'b0, r_run} >= i_cfg.min_run)
                                 && ({1'b0, r_run} <= i_cfg.max_run);
            PH_GAP1,
            PH_GAP2:   exit_ok = !i_pixel && within1;
            PH_CENTER: exit_ok = i_pixel && within3;
            PH_OUTER2: exit_ok = (i_pixel && within1) || (col_p1 >= line_cap);
            PH_MARK:   exit_ok = 1'b0;
            default:   exit_ok = 1'b0;
        endcase
    end

    assign advance = step_edge && exit_ok;

    // Phase and run count after the edge, then the overlong-run check
    always_comb begin
        if (advance) begin
            ph_a = t_phase'(r_phase + 3'd1);
        end else if (step_edge) begin
            ph_a = PH_IDLE;
        end else begin
            ph_a = r_phase;
        end
        n_run    = step_edge ? 12'd1 : run_inc;
        n_run_w3 = {3'b000, n_run};
        if (ph_a == PH_CENTER) begin
            limit = r_upper3;
        end else if (advance && (r_phase == PH_OUTER1)) begin
            limit = {2'b00, n_upper};
        end else begin
            limit = {2'b00, r_upper};
        end
        priority if (ph_a == PH_IDLE) begin
            overrun = 1'b0;
        end else if (ph_a == PH_OUTER1) begin
            overrun = {1'b0, n_run} > i_cfg.max_run;
        end else begin
            overrun = (n_run_w3 > limit) || ({1'b0, n_run} > i_cfg.max_run);
        end
        n_phase = overrun ? PH_IDLE : ph_a;
    end

    // Machine state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_prev_pixel <= 1'b0;
            r_prev_aux   <= 1'b0;
            r_prev_row   <= '0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_prev_pixel <= i_pixel;
            r_prev_aux   <= i_aux_pixel;
            r_prev_row   <= i_row;
        end
    end

    // Run lengths, columns and bounds
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_run <= n_run;
            if (step_edge && (r_phase == PH_IDLE)) begin
                r_first_col <= i_column;
                r_last_col  <= i_column;
            end
            if (step_edge && (r_phase == PH_OUTER2)) begin
                r_last_col <= i_column;
            end
            if (advance && (r_phase == PH_OUTER1)) begin
                r_run1   <= r_run;
                r_lower  <= n_lower;
                r_upper  <= n_upper;
                r_lower3 <= {2'b00, n_lower} + {1'b0, n_lower, 1'b0};
                r_upper3 <= {2'b00, n_upper} + {1'b0, n_upper, 1'b0};
            end
            if (advance && (r_phase == PH_GAP1)) begin
                r_run2 <= r_run;
            end
            if (advance && (r_phase == PH_CENTER)) begin
                r_run3 <= r_run;
            end
        end
    end

    // Marker goes out on the step taken in the marker phase
    assign o_emit              = (r_phase == PH_MARK);
    assign o_result.start_x    = r_first_col;
    assign o_result.end_x      = r_last_col;
    assign o_result.marker_row = r_prev_row;
    assign o_result.outer_run  = r_run1;
    assign o_result.gap_run    = r_run2;
    assign o_result.center_run = r_run3;

endmodule

@@ design/scanline_finder_pattern_detector_core.sv @@
// Top level: configuration registers, run-length scanner and result register.
// A marker is released by the pixel transaction after the one that closes the
// last outer run, and is on the outputs in the cycle after that releasing transaction.
// Throughput: one pixel transaction per cycle while the input is ready.
// The input is ready whenever the result register is empty or being drained.
// Reset (synchronous, active low) returns the scanner to idle, empties the result
// register and loads the default configuration.
module scanline_finder_pattern_detector_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [sfpd_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [sfpd_pkg::DATA_W-1:0]  i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [sfpd_pkg::COORD_W-1:0] i_column,
    input  logic [sfpd_pkg::COORD_W-1:0] i_row,
    input  logic                         i_pixel,
    input  logic                         i_aux_pixel,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [sfpd_pkg::COORD_W-1:0] o_start_x,
    output logic [sfpd_pkg::COORD_W-1:0] o_end_x,
    output logic [sfpd_pkg::COORD_W-1:0] o_marker_row,
    output logic [sfpd_pkg::COORD_W-1:0] o_outer_run,
    output logic [sfpd_pkg::COORD_W-1:0] o_gap_run,
    output logic [sfpd_pkg::COORD_W-1:0] o_center_run
);
    import sfpd_pkg::*;

    t_cfg    r_cfg;
    t_result r_result, scan_result;
    logic    r_out_valid;
    logic    step, scan_emit;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_length      <= RST_LINE_LENGTH;
            r_cfg.max_run          <= RST_MAX_RUN;
            r_cfg.min_run          <= RST_MIN_RUN;
            r_cfg.tolerance_q8     <= RST_TOL;
            r_cfg.inv_tolerance_q8 <= RST_INV_TOL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LINE_LENGTH: r_cfg.line_length      <= i_cfg_data[CFG_W-1:0];
                CFG_MAX_RUN:     r_cfg.max_run          <= i_cfg_data[CFG_W-1:0];
                CFG_MIN_RUN:     r_cfg.min_run          <= i_cfg_data[CFG_W-1:0];
                CFG_TOL:         r_cfg.tolerance_q8     <= i_cfg_data[TOL_W-1:0];
                CFG_INV_TOL:     r_cfg.inv_tolerance_q8 <= i_cfg_data[INV_W-1:0];
                default: ;
            endcase
        end
    end

    // Input handshake
    assign o_ready = !r_out_valid || i_ready;
    assign step    = i_valid && o_ready;

    sfpd_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_step      (step),
        .i_column    (i_column),
        .i_row       (i_row),
        .i_pixel     (i_pixel),
        .i_aux_pixel (i_aux_pixel),
        .o_emit      (scan_emit),
        .o_result    (scan_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && scan_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && scan_emit) begin
            r_result <= scan_result;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_start_x    = r_result.start_x;
    assign o_end_x      = r_result.end_x;
    assign o_marker_row = r_result.marker_row;
    assign o_outer_run  = r_result.outer_run;
    assign o_gap_run    = r_result.gap_run;
    assign o_center_run = r_result.center_run;

endmodule

@@ design/sfpd_checker.sv @@
// Port-level checks for the scanline finder pattern detector, bound to the top level.
module sfpd_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_ready,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic [sfpd_pkg::COORD_W-1:0] o_start_x,
    input logic [sfpd_pkg::COORD_W-1:0] o_end_x,
    input logic [sfpd_pkg::COORD_W-1:0] o_marker_row,
    input logic [sfpd_pkg::COORD_W-1:0] o_outer_run,
    input logic [sfpd_pkg::COORD_W-1:0] o_gap_run,
    input logic [sfpd_pkg::COORD_W-1:0] o_center_run
);

    // A stalled result holds its transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_start_x) && $stable(o_end_x)
            && $stable(o_marker_row) && $stable(o_outer_run) && $stable(o_gap_run)
            && $stable(o_center_run))
        else $error("result changed while stalled");

    // Reset empties the result register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // An empty result register never blocks the input
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty result register");

    // Every reported run was counted at least once
    a_runs_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_outer_run != '0) && (o_gap_run != '0) && (o_center_run != '0))
        else $error("marker with an empty run");

endmodule

bind scanline_finder_pattern_detector_core sfpd_checker u_sfpd_checker (.*);

@@ dv/scanline_finder_pattern_detector_checker.sv @@
// Scoreboard for the finder pattern detector: mirrors the scanner and checks each marker.
module scanline_finder_pattern_detector_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sfpd_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [sfpd_pkg::DATA_W-1:0]   i_cfg_data,
    input  logic                          i_px_valid,
    input  logic                          i_px_ready,
    input  logic [sfpd_pkg::COORD_W-1:0]  i_column,
    input  logic [sfpd_pkg::COORD_W-1:0]  i_row,
    input  logic                          i_pixel,
    input  logic                          i_aux_pixel,
    input  logic                          i_mk_valid,
    input  logic                          i_mk_ready,
    input  sfpd_pkg::t_result             i_marker,
    output int                            o_pending,
    output int                            o_markers,
    output int                            o_errors
);
    import sfpd_pkg::*;

    localparam logic [COORD_W-1:0] COUNT_MAX = 12'hFFF;
    localparam logic [BOUND_W-1:0] BOUND_MAX = 13'h1FFF;
    localparam int                 MAX_PRINTS = 40;

    // Scan phases: idle, five runs of the 1:1:3:1:1 pattern, marker, spare
    typedef enum logic [2:0] {
        SCAN_IDLE, SCAN_OUTER1, SCAN_GAP1, SCAN_CENTER,
        SCAN_GAP2, SCAN_OUTER2, SCAN_MARK, SCAN_SPARE
    } scan_ph_e;

    // Mirrored configuration and scanner state
    t_cfg               cfg_q;
    scan_ph_e           ph;
    logic [COORD_W-1:0] run_len [0:6];
    logic [COORD_W-1:0] first_col, last_col, held_row;
    logic [BOUND_W-1:0] lo_bnd, hi_bnd;
    logic               prev_pix, prev_aux;

    t_result marker_q [$];
    t_result want;
    int      error_cnt = 0;
    int      marker_total = 0;

    task automatic scan_restart(input logic [COORD_W-1:0] row);
        held_row  = row;
        first_col = '0;
        last_col  = '0;
        foreach (run_len[k]) run_len[k] = '0;
        ph        = SCAN_IDLE;
        lo_bnd    = '0;
        hi_bnd    = '0;
    endtask

    // Run length against the latched bounds, scaled for the center run
    function automatic bit run_fits(input logic [COORD_W-1:0] len, input int s);
        return int'(len) >= int'(lo_bnd) * s && int'(len) <= int'(hi_bnd) * s &&
               int'(len) <= int'(cfg_q.max_run) * s;
    endfunction

    // Exit test of the current phase on an edge; the first run also latches the bounds
    function automatic bit phase_exit_ok(input logic [COORD_W-1:0] col, input logic pix);
        longint prod;
        int     ll;
        ll = (cfg_q.line_length > LINE_MAX) ? int'(LINE_MAX) : int'(cfg_q.line_length);
        case (ph)
            SCAN_IDLE: return !pix && col != '0 && prev_aux;
            SCAN_OUTER1: begin
                prod   = (longint'(run_len[1]) * longint'(cfg_q.tolerance_q8)) >> 8;
                lo_bnd = (prod > BOUND_MAX) ? BOUND_MAX : prod[BOUND_W-1:0];
                prod   = (longint'(run_len[1]) * longint'(cfg_q.inv_tolerance_q8)) >> 8;
                hi_bnd = (prod > BOUND_MAX) ? BOUND_MAX : prod[BOUND_W-1:0];
                return pix && run_len[1] >= cfg_q.min_run && run_len[1] <= cfg_q.max_run;
            end
            SCAN_GAP1, SCAN_GAP2: return !pix && run_fits(run_len[ph], 1);
            SCAN_CENTER: return pix && run_fits(run_len[3], 3);
            SCAN_OUTER2: return (pix && run_fits(run_len[5], 1)) || (int'(col) + 1 >= ll);
            default: return 1'b0;
        endcase
    endfunction

    // One pixel transaction through the scanner; queues the marker it releases
    task automatic scan_pixel(input logic [COORD_W-1:0] col, row,
                              input logic pix, aux);
        t_result mk;
        bit      emit;
        int      lim;
        emit = 1'b0;
        mk   = '0;
        if (pix != prev_pix || ph >= SCAN_MARK) begin
            if (ph == SCAN_IDLE) begin
                first_col = col;
                last_col  = col;
            end
            if (ph == SCAN_OUTER2)
                last_col = col;
            if (ph == SCAN_MARK) begin
                mk.start_x    = first_col;
                mk.end_x      = last_col;
                mk.marker_row = held_row;
                mk.outer_run  = run_len[1];
                mk.gap_run    = run_len[2];
                mk.center_run = run_len[3];
                emit          = 1'b1;
            end
            if (phase_exit_ok(col, pix))
                ph = scan_ph_e'(ph + 1);
            else
                scan_restart(row);
        end
        if (ph == SCAN_SPARE)
            ph = SCAN_IDLE;

        // Count the pixel into the current run, saturating
        if (run_len[ph] != COUNT_MAX)
            run_len[ph] = run_len[ph] + 1'b1;
        if (ph == SCAN_OUTER1) begin
            if (run_len[ph] > cfg_q.max_run)
                scan_restart(row);
        end else if (ph > SCAN_OUTER1) begin
            lim = int'(hi_bnd);
            if (ph == SCAN_CENTER)
                lim = lim * 3;
            if (int'(run_len[ph]) > lim || run_len[ph] > cfg_q.max_run)
                scan_restart(row);
        end

        held_row = row;
        prev_pix = pix;
        prev_aux = aux;
        if (emit)
            marker_q.push_back(mk);
    endtask

    task automatic check_field(input string name, input logic [COORD_W-1:0] exp_v, act_v);
        if (exp_v !== act_v) begin
            if (error_cnt < MAX_PRINTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            error_cnt++;
        end
    endtask

    // Register writes, marker compare, then prediction of the accepted pixel
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_q = '{line_length: RST_LINE_LENGTH, max_run: RST_MAX_RUN,
                      min_run: RST_MIN_RUN, tolerance_q8: RST_TOL,
                      inv_tolerance_q8: RST_INV_TOL};
            scan_restart('0);
            prev_pix = 1'b0;
            prev_aux = 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LINE_LENGTH: cfg_q.line_length      = i_cfg_data[CFG_W-1:0];
                    CFG_MAX_RUN:     cfg_q.max_run          = i_cfg_data[CFG_W-1:0];
                    CFG_MIN_RUN:     cfg_q.min_run          = i_cfg_data[CFG_W-1:0];
                    CFG_TOL:         cfg_q.tolerance_q8     = i_cfg_data[TOL_W-1:0];
                    CFG_INV_TOL:     cfg_q.inv_tolerance_q8 = i_cfg_data[INV_W-1:0];
                    default: ;
                endcase
            end
            if (i_mk_valid && i_mk_ready) begin
                marker_total++;
                if (marker_q.size() == 0) begin
                    if (error_cnt < MAX_PRINTS)
                        $display("%0t: marker mismatch, expected none, got start_x %0d end_x %0d",
                                 $time, i_marker.start_x, i_marker.end_x);
                    error_cnt++;
                end else begin
                    want = marker_q.pop_front();
                    check_field("start_x", want.start_x, i_marker.start_x);
                    check_field("end_x", want.end_x, i_marker.end_x);
                    check_field("marker_row", want.marker_row, i_marker.marker_row);
                    check_field("outer_run", want.outer_run, i_marker.outer_run);
                    check_field("gap_run", want.gap_run, i_marker.gap_run);
                    check_field("center_run", want.center_run, i_marker.center_run);
                end
            end
            if (i_px_valid && i_px_ready)
                scan_pixel(i_column, i_row, i_pixel, i_aux_pixel);
        end
        o_pending <= marker_q.size();
        o_markers <= marker_total;
        o_errors  <= error_cnt;
    end

endmodule

@@ dv/scanline_finder_pattern_detector_core_tb.sv @@
// Testbench top for the finder pattern detector: stimulus, handshakes and verdict.
module scanline_finder_pattern_detector_core_tb;
    import sfpd_pkg::*;

    localparam int LIMIT  = 1_000_000;
    localparam int SETTLE = 4;
    // Indexes outside the register map, must be ignored
    localparam logic [IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [IDX_W-1:0]    i_cfg_idx;
    logic [DATA_W-1:0]   i_cfg_data;
    logic                i_valid;
    logic                o_ready;
    logic [COORD_W-1:0]  i_column;
    logic [COORD_W-1:0]  i_row;
    logic                i_pixel;
    logic                i_aux_pixel;
    logic                o_valid;
    logic                i_ready = 1'b1;
    logic [COORD_W-1:0]  o_start_x, o_end_x, o_marker_row;
    logic [COORD_W-1:0]  o_outer_run, o_gap_run, o_center_run;

    int pending, markers, errors;
    int gap_pct   = 0;
    int stall_pct = 0;
    int cycles    = 0;
    int sent      = 0;
    int pat_cnt   = 0;
    int line_cfg  = 640;

    always #5 i_clk = ~i_clk;

    // Receiver side: random stalls on the marker channel
    always @(posedge i_clk)
        i_ready <= ($urandom_range(99) >= stall_pct);

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("scanline_finder_pattern_detector_core test failed");
            $finish;
        end
    end

    scanline_finder_pattern_detector_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_column     (i_column),
        .i_row        (i_row),
        .i_pixel      (i_pixel),
        .i_aux_pixel  (i_aux_pixel),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_start_x    (o_start_x),
        .o_end_x      (o_end_x),
        .o_marker_row (o_marker_row),
        .o_outer_run  (o_outer_run),
        .o_gap_run    (o_gap_run),
        .o_center_run (o_center_run)
    );

    scanline_finder_pattern_detector_checker u_marker_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_px_valid  (i_valid),
        .i_px_ready  (o_ready),
        .i_column    (i_column),
        .i_row       (i_row),
        .i_pixel     (i_pixel),
        .i_aux_pixel (i_aux_pixel),
        .i_mk_valid  (o_valid),
        .i_mk_ready  (i_ready),
        .i_marker    ({o_start_x, o_end_x, o_marker_row,
                       o_outer_run, o_gap_run, o_center_run}),
        .o_pending   (pending),
        .o_markers   (markers),
        .o_errors    (errors)
    );

    // One pixel transaction, with a random idle gap in front of it
    task automatic send_pixel(input logic [COORD_W-1:0] col, row, input logic pix, aux);
        if ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < gap_pct);
        end
        i_valid     <= 1'b1;
        i_column    <= col;
        i_row       <= row;
        i_pixel     <= pix;
        i_aux_pixel <= aux;
        do @(posedge i_clk); while (!o_ready);
        sent++;
    endtask

    // Hold off the sender until every marker is out, then let the pipe settle
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic set_config(input int line, max_r, min_r, tol, inv_tol);
        write_reg(CFG_LINE_LENGTH, DATA_W'(line));
        write_reg(CFG_MAX_RUN, DATA_W'(max_r));
        write_reg(CFG_MIN_RUN, DATA_W'(min_r));
        write_reg(CFG_TOL, DATA_W'(tol));
        write_reg(CFG_INV_TOL, DATA_W'(inv_tol));
        i_cfg_we <= 1'b0;
        line_cfg = line;
    endtask

    // Lead of set pixels, then 1:1:3:1:1 runs (exact or jittered), then closing pixels
    task automatic send_pattern(input int unit_max);
        int                 run_unit, jit, lead, trail, span, line_eff;
        int                 runs [5];
        bit                 exact;
        logic [COORD_W-1:0] col, row;
        run_unit = ($urandom_range(7) == 0) ? $urandom_range(1, unit_max)
                                            : $urandom_range(1, (unit_max < 6) ? unit_max : 6);
        exact = ($urandom_range(1) == 1);
        jit   = run_unit / 3 + 1;
        span  = 0;
        for (int k = 0; k < 5; k++) begin
            runs[k] = (k == 2) ? 3 * run_unit : run_unit;
            if (!exact)
                runs[k] = runs[k] + int'($urandom_range(2 * jit)) - jit;
            if (runs[k] < 1)
                runs[k] = 1;
            span += runs[k];
        end
        lead     = $urandom_range(1, 3);
        trail    = $urandom_range(1, 3);
        line_eff = (line_cfg > 4096) ? 4096 : line_cfg;
        row      = COORD_W'($urandom());
        // Now and then end the last outer run at or near the last column of the line
        if ($urandom_range(3) == 0)
            col = COORD_W'(line_eff - lead - span - 1 + int'($urandom_range(2)));
        else
            col = COORD_W'($urandom());

        for (int k = 0; k < lead; k++) begin
            send_pixel(col, row, 1'b1,
                       (k == lead - 1) ? ($urandom_range(7) != 0) : ($urandom_range(1) == 1));
            col = col + 1'b1;
        end
        for (int k = 0; k < 5; k++) begin
            for (int n = 0; n < runs[k]; n++) begin
                send_pixel(col, row, k[0], $urandom_range(1) == 1);
                col = col + 1'b1;
            end
        end
        for (int k = 0; k < trail; k++) begin
            send_pixel(col, row, 1'b1, $urandom_range(1) == 1);
            col = col + 1'b1;
        end
    endtask

    // Mostly patterns, some noise bursts; stops once item and marker counts are met, or at four times the item target
    task automatic run_phase(input int gap, stall, unit_max, target, goal);
        int first_item, first_marker, burst;
        gap_pct      = gap;
        stall_pct    = stall;
        first_item   = sent;
        first_marker = markers;
        while ((sent - first_item < target || markers - first_marker < goal) &&
               sent - first_item < 4 * target) begin
            if ($urandom_range(3) == 0) begin
                burst = $urandom_range(1, 8);
                repeat (burst)
                    send_pixel(COORD_W'($urandom()), COORD_W'($urandom()),
                               $urandom_range(1) == 1, $urandom_range(1) == 1);
            end else begin
                send_pattern(unit_max);
                pat_cnt++;
                if (pat_cnt % 20 == 0)
                    drain();
            end
        end
    endtask

    initial begin
        logic [14:0] dir_pix;
        dir_pix = 15'b010001011010000;

        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_LINE_LENGTH;
        i_cfg_data  <= '0;
        i_valid     <= 1'b0;
        i_column    <= '0;
        i_row       <= '0;
        i_pixel     <= 1'b0;
        i_aux_pixel <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, refused starts, one exact marker, an overlong center
        send_pixel(12'd0, 12'd0, 1'b0, 1'b0);
        send_pixel(12'd4095, 12'd4095, 1'b1, 1'b1);
        send_pixel(12'd0, 12'd5, 1'b0, 1'b1);   // start on column zero is refused
        send_pixel(12'd1, 12'd5, 1'b1, 1'b0);
        send_pixel(12'd2, 12'd5, 1'b0, 1'b0);   // start without aux is refused
        send_pixel(12'd3, 12'd5, 1'b1, 1'b1);
        for (int k = 0; k < 15; k++)
            send_pixel(COORD_W'(4 + k), 12'd6, dir_pix[14-k], 1'b1);
        drain();

        // Default tolerances, no idling; spare indexes written first
        write_reg(CFG_SPARE_LO, 16'hFFFF);
        write_reg(CFG_SPARE_HI, 16'h0001);
        set_config(640, 128, 1, 179, 366);
        run_phase(0, 0, 20, 380, 6);
        drain();

        // Loosest bounds, sender idling
        set_config(4096, 4096, 0, 0, 65535);
        run_phase(73, 0, 60, 380, 6);
        drain();

        // Exact ratios only, zero line length, receiver stalling
        set_config(0, 40, 2, 256, 256);
        run_phase(0, 73, 13, 380, 6);
        drain();

        // Oversized line length, short runs, both sides idling
        set_config(8191, 12, 1, 128, 512);
        run_phase(20, 20, 4, 380, 6);
        drain();

        // Degenerate settings: nothing can complete
        set_config(1, 0, 4096, 256, 0);
        run_phase(20, 20, 3, 120, 0);
        drain();

        if (errors == 0)
            $display("scanline_finder_pattern_detector_core test passed");
        else
            $display("scanline_finder_pattern_detector_core test failed");
        $finish;
    end

endmodule
